// ===== rtl/ces_pkg.sv =====
// Package for the cycle event scheduler: widths, limits and stream layout.
// Used by every module of the block; depends on nothing.
package ces_pkg;

  localparam int unsigned DefaultSlots = 4;
  localparam int unsigned TimeW        = 32;
  localparam int unsigned SlotW        = 2;
  localparam int unsigned MaxFires     = 4;
  localparam int unsigned FireCntW     = $clog2(MaxFires + 1);
  localparam int unsigned FireIdxW     = $clog2(MaxFires);

  localparam int unsigned InFieldW  = SlotW + 2 * TimeW;
  localparam int unsigned InDataW   = ((InFieldW + 7) / 8) * 8;
  localparam int unsigned OutFieldW = SlotW + 2 * TimeW;
  localparam int unsigned OutDataW  = ((OutFieldW + 7) / 8) * 8;

  localparam logic signed [TimeW-1:0] NoDist = 32'sh7fff_ffff;

endpackage

// ===== rtl/ces_slot_store.sv =====
// Due-time memory of the cycle event scheduler with per-slot pending flags.
// One write port, one flag clear port and one registered read port; uses ces_pkg.
module ces_slot_store #(
  parameter int unsigned EVENT_SLOTS = ces_pkg::DefaultSlots,
  parameter int unsigned IdxW        = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       wr_en_i,
  input  logic [IdxW-1:0]            wr_idx_i,
  input  logic [ces_pkg::TimeW-1:0]  wr_time_i,
  input  logic                       clr_en_i,
  input  logic [IdxW-1:0]            clr_idx_i,
  input  logic                       rd_en_i,
  input  logic [IdxW-1:0]            rd_idx_i,
  output logic                       rd_vld_o,
  output logic [IdxW-1:0]            rd_idx_o,
  output logic [ces_pkg::TimeW-1:0]  rd_time_o,
  output logic                       rd_pend_o
);
  import ces_pkg::*;

  logic [TimeW-1:0]       mem_q [EVENT_SLOTS];
  logic [EVENT_SLOTS-1:0] pend_q;
  logic [TimeW-1:0]       rd_time_q;
  logic                   rd_pend_q;
  logic                   rd_vld_q;
  logic [IdxW-1:0]        rd_idx_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_time_i;
    end
    if (rd_en_i) begin
      rd_time_q <= mem_q[rd_idx_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= '0;
      rd_pend_q <= 1'b0;
      rd_vld_q  <= 1'b0;
      rd_idx_q  <= '0;
    end else begin
      if (wr_en_i) begin
        pend_q[wr_idx_i] <= 1'b1;
      end
      if (clr_en_i) begin
        pend_q[clr_idx_i] <= 1'b0;
      end
      rd_vld_q <= rd_en_i;
      if (rd_en_i) begin
        rd_idx_q  <= rd_idx_i;
        rd_pend_q <= pend_q[rd_idx_i];
      end
    end
  end

  assign rd_vld_o  = rd_vld_q;
  assign rd_idx_o  = rd_idx_q;
  assign rd_time_o = rd_time_q;
  assign rd_pend_o = rd_pend_q;

endmodule

// ===== rtl/cycle_event_scheduler.sv =====
// Schedule item: its result is registered once the output is free, then the next is taken.
// Run item: each selection pass reads all slots from the due-time memory; a run makes
// fires + 1 passes (at most 5), then emits one result per cycle while the output is not stalled.
// One item is in work at a time; the last result may wait in the output register meanwhile.
// Reset clears all pending flags and next-due at once; no clearing pass is needed.
module cycle_event_scheduler #(
  parameter int unsigned EVENT_SLOTS = ces_pkg::DefaultSlots
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // slot [1:0], time_ref [33:2], delay [65:34], zero pad
  input  logic [ces_pkg::InDataW-1:0]   s_axis_tdata_i,
  // mode
  input  logic                          s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // fired_slot [1:0], fired_time [33:2], next_due [65:34], zero pad
  output logic [ces_pkg::OutDataW-1:0]  m_axis_tdata_o,
  // fired
  output logic                          m_axis_tuser_o,
  output logic                          m_axis_tlast_o
);
  import ces_pkg::*;

  localparam int unsigned IdxW = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
  localparam int unsigned CntW = $clog2(EVENT_SLOTS + 1);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StDecide,
    StEmit
  } state_e;

  state_e                   state_q;
  logic [TimeW-1:0]         tref_q;
  logic [CntW-1:0]          rd_cnt_q;
  logic                     best_found_q;
  logic [IdxW-1:0]          best_idx_q;
  logic [TimeW-1:0]         best_time_q;
  logic signed [TimeW-1:0]  best_dist_q;
  logic [FireCntW-1:0]      fire_cnt_q;
  logic [FireCntW-1:0]      emit_idx_q;
  logic [IdxW-1:0]          fire_idx_q  [MaxFires];
  logic [TimeW-1:0]         fire_time_q [MaxFires];
  logic [TimeW-1:0]         next_due_q;
  logic                     m_valid_q;
  logic [OutDataW-1:0]      m_data_q;
  logic                     m_user_q;
  logic                     m_last_q;

  logic [SlotW-1:0]         in_slot;
  logic [TimeW-1:0]         in_time;
  logic [TimeW-1:0]         in_delay;
  logic [TimeW-1:0]         when_sum;
  logic [TimeW-1:0]         when_odd;
  logic                     slot_ok;
  logic                     accept;
  logic                     sched;
  logic                     wr_en;
  logic                     cancel;
  logic                     clr_en;
  logic [IdxW-1:0]          clr_idx;
  logic                     rd_en;
  logic                     rd_vld;
  logic [IdxW-1:0]          rd_idx;
  logic [TimeW-1:0]         rd_time;
  logic                     rd_pend;
  logic signed [TimeW-1:0]  rd_dist;
  logic                     better;
  logic                     scan_done;
  logic                     fire_ok;
  logic                     out_free;
  logic                     emit_fired;
  logic                     emit_last;
  logic [FireIdxW-1:0]      emit_sel;
  logic [SlotW-1:0]         emit_slot;
  logic [TimeW-1:0]         emit_time;
  logic                     sched_lower;

  assign in_slot  = s_axis_tdata_i[SlotW-1:0];
  assign in_time  = s_axis_tdata_i[SlotW +: TimeW];
  assign in_delay = s_axis_tdata_i[SlotW+TimeW +: TimeW];
  assign when_sum = in_time + in_delay;
  assign when_odd = when_sum | TimeW'(1);
  assign slot_ok  = (32'(in_slot) < EVENT_SLOTS);

  assign accept = s_axis_tvalid_i && (state_q == StIdle);
  assign sched  = accept && !s_axis_tuser_i;
  assign wr_en  = sched && slot_ok && (when_sum != '0);
  assign cancel = sched && slot_ok && (when_sum == '0);

  assign sched_lower = (next_due_q == '0) || (signed'(next_due_q - when_odd) > 0);

  assign rd_en     = (state_q == StScan) && (rd_cnt_q < CntW'(EVENT_SLOTS));
  assign rd_dist   = signed'(rd_time - tref_q);
  assign better    = rd_vld && rd_pend && (rd_dist < best_dist_q);
  assign scan_done = rd_vld && (rd_idx == IdxW'(EVENT_SLOTS - 1));
  assign fire_ok   = best_found_q && (best_dist_q <= 0) &&
                     (fire_cnt_q < FireCntW'(MaxFires));

  assign clr_en  = cancel || ((state_q == StDecide) && fire_ok);
  assign clr_idx = cancel ? IdxW'(in_slot) : best_idx_q;

  assign out_free   = !m_valid_q || m_axis_tready_i;
  assign emit_fired = emit_idx_q < fire_cnt_q;
  assign emit_last  = (emit_idx_q + FireCntW'(1)) >= fire_cnt_q;
  assign emit_sel   = emit_idx_q[FireIdxW-1:0];
  assign emit_slot  = emit_fired ? SlotW'(fire_idx_q[emit_sel]) : '0;
  assign emit_time  = emit_fired ? fire_time_q[emit_sel] : '0;

  ces_slot_store #(
    .EVENT_SLOTS (EVENT_SLOTS),
    .IdxW        (IdxW)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_idx_i  (IdxW'(in_slot)),
    .wr_time_i (when_odd),
    .clr_en_i  (clr_en),
    .clr_idx_i (clr_idx),
    .rd_en_i   (rd_en),
    .rd_idx_i  (rd_cnt_q[IdxW-1:0]),
    .rd_vld_o  (rd_vld),
    .rd_idx_o  (rd_idx),
    .rd_time_o (rd_time),
    .rd_pend_o (rd_pend)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      tref_q       <= '0;
      rd_cnt_q     <= '0;
      best_found_q <= 1'b0;
      best_idx_q   <= '0;
      best_time_q  <= '0;
      best_dist_q  <= NoDist;
      fire_cnt_q   <= '0;
      emit_idx_q   <= '0;
      fire_idx_q   <= '{default: '0};
      fire_time_q  <= '{default: '0};
      next_due_q   <= '0;
      m_valid_q    <= 1'b0;
      m_data_q     <= '0;
      m_user_q     <= 1'b0;
      m_last_q     <= 1'b0;
    end else begin
      if (m_valid_q && m_axis_tready_i && (state_q != StEmit)) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (accept) begin
            tref_q       <= in_time;
            fire_cnt_q   <= '0;
            emit_idx_q   <= '0;
            rd_cnt_q     <= '0;
            best_found_q <= 1'b0;
            best_dist_q  <= NoDist;
            if (s_axis_tuser_i) begin
              state_q <= StScan;
            end else begin
              if (wr_en && sched_lower) begin
                next_due_q <= when_odd;
              end
              state_q <= StEmit;
            end
          end
        end
        StScan: begin
          if (rd_en) begin
            rd_cnt_q <= rd_cnt_q + CntW'(1);
          end
          if (better) begin
            best_found_q <= 1'b1;
            best_idx_q   <= rd_idx;
            best_time_q  <= rd_time;
            best_dist_q  <= rd_dist;
          end
          if (scan_done) begin
            state_q <= StDecide;
          end
        end
        StDecide: begin
          if (fire_ok) begin
            fire_idx_q[fire_cnt_q[FireIdxW-1:0]]  <= best_idx_q;
            fire_time_q[fire_cnt_q[FireIdxW-1:0]] <= best_time_q;
            fire_cnt_q   <= fire_cnt_q + FireCntW'(1);
            rd_cnt_q     <= '0;
            best_found_q <= 1'b0;
            best_dist_q  <= NoDist;
            state_q      <= StScan;
          end else begin
            next_due_q <= best_found_q ? best_time_q : '0;
            emit_idx_q <= '0;
            state_q    <= StEmit;
          end
        end
        StEmit: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_user_q  <= emit_fired;
            m_last_q  <= emit_last;
            m_data_q  <= OutDataW'({next_due_q, emit_time, emit_slot});
            if (emit_last) begin
              state_q <= StIdle;
            end else begin
              emit_idx_q <= emit_idx_q + FireCntW'(1);
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == StIdle);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;
  assign m_axis_tlast_o  = m_last_q;

endmodule

// ===== rtl/ces_checker.sv =====
// Port-level checks for the cycle event scheduler, bound to the top level.
// Watches the result stream only; uses ces_pkg for the stream layout.
module ces_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [ces_pkg::OutDataW-1:0]  m_axis_tdata_o,
  input logic                          m_axis_tuser_o,
  input logic                          m_axis_tlast_o
);
  import ces_pkg::*;

  logic [SlotW-1:0] out_slot;
  logic [TimeW-1:0] out_time;
  logic [TimeW-1:0] out_next;

  assign out_slot = m_axis_tdata_o[SlotW-1:0];
  assign out_time = m_axis_tdata_o[SlotW +: TimeW];
  assign out_next = m_axis_tdata_o[SlotW+TimeW +: TimeW];

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped before it was taken");

  a_idle_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tlast_o)
    else $error("a result without a fire is not the only result of its item");

  a_idle_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> (out_slot == '0) && (out_time == '0))
    else $error("fire fields set on a result without a fire");

  a_fire_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> out_time[0])
    else $error("fired time is not an odd stored due time");

  a_next_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> out_next[0] || (out_next == '0))
    else $error("next due time is neither zero nor a stored due time");

endmodule

bind cycle_event_scheduler ces_checker u_ces_checker (.*);
